### hw/rtl/drfe_pkg.sv
// Shared types, constants and helper functions of the delimited record field extractor.
`default_nettype none

package drfe_pkg;

   localparam int DEF_MAX_RECORD_BYTES = 65536;
   localparam int QUEUE_DEPTH          = 2;
   localparam int CNT_W                = 15;
   localparam int CSR_IDX_W            = 2;
   localparam int CSR_DATA_W           = 16;
   localparam int SPAN_START_W         = 16;
   localparam int SPAN_LEN_W           = 17;
   localparam int SPAN_START_MAX       = 65535;
   localparam int SPAN_LEN_MAX         = 65536;

   localparam logic [7:0] DELIM_FIELD = 8'h1E;
   localparam logic [7:0] DELIM_VALUE = 8'h1D;
   localparam logic [7:0] DELIM_SUB   = 8'h1C;

   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_NUMBER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_NUMBER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBVALUE_NUMBER = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       no_byte;
   } req_type;

   typedef struct packed {
      logic [SPAN_START_W-1:0] span_start;
      logic [SPAN_LEN_W-1:0]   span_length;
      logic                    record_overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      CLS_PLAIN,
      CLS_FIELD,
      CLS_VALUE,
      CLS_SUB
   } cls_type;

   typedef struct packed {
      cls_type cls;
      logic    has_byte;
      logic    last;
   } qitem_type;

   typedef enum logic [1:0] {
      DEPTH_RECORD,
      DEPTH_FIELD,
      DEPTH_VALUE,
      DEPTH_SUB
   } depth_type;

   typedef struct packed {
      logic             none;
      depth_type        depth;
      logic [CNT_W-1:0] fe;
      logic [CNT_W-1:0] ve;
      logic [CNT_W-1:0] se;
   } sel_type;

   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      c = CLS_PLAIN;
      if (b == DELIM_FIELD) begin
         c = CLS_FIELD;
      end else if (b == DELIM_VALUE) begin
         c = CLS_VALUE;
      end else if (b == DELIM_SUB) begin
         c = CLS_SUB;
      end
      return c;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      r = (c == CNT_MAX) ? CNT_MAX : c + CNT_ONE;
      return r;
   endfunction

   function automatic sel_type sel_decode(input logic [CSR_DATA_W-1:0] f,
                                          input logic [CSR_DATA_W-1:0] v,
                                          input logic [CSR_DATA_W-1:0] s);
      sel_type r;
      logic    fz;
      logic    vz;
      logic    sz;
      fz      = (f == '0);
      vz      = (v == '0);
      sz      = (s == '0);
      r.none  = f[CSR_DATA_W-1] | v[CSR_DATA_W-1] | s[CSR_DATA_W-1];
      r.fe    = fz ? CNT_ONE : f[CNT_W-1:0];
      r.ve    = vz ? CNT_ONE : v[CNT_W-1:0];
      r.se    = s[CNT_W-1:0];
      if (fz && vz && sz) begin
         r.depth = DEPTH_RECORD;
      end else if (vz && sz) begin
         r.depth = DEPTH_FIELD;
      end else if (sz) begin
         r.depth = DEPTH_VALUE;
      end else begin
         r.depth = DEPTH_SUB;
      end
      return r;
   endfunction

   function automatic logic sel_match(input sel_type sel,
                                      input logic [CNT_W-1:0] fc,
                                      input logic [CNT_W-1:0] vc,
                                      input logic [CNT_W-1:0] sc);
      logic m;
      unique case (sel.depth)
         DEPTH_RECORD: m = 1'b1;
         DEPTH_FIELD:  m = (fc == sel.fe);
         DEPTH_VALUE:  m = (fc == sel.fe) && (vc == sel.ve);
         DEPTH_SUB:    m = (fc == sel.fe) && (vc == sel.ve) && (sc == sel.se);
         default:      m = 1'b0;
      endcase
      return m & ~sel.none;
   endfunction

   function automatic logic is_term(input sel_type sel, input cls_type c);
      logic t;
      unique case (c)
         CLS_FIELD: t = (sel.depth != DEPTH_RECORD);
         CLS_VALUE: t = (sel.depth == DEPTH_VALUE) || (sel.depth == DEPTH_SUB);
         CLS_SUB:   t = (sel.depth == DEPTH_SUB);
         default:   t = 1'b0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/drfe_front.sv
// Input stage: takes items, classifies the byte and hands the result to the queue.
`default_nettype none

module drfe_front import drfe_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req_item,
   output logic           push_valid,
   input  wire logic      push_ready,
   output qitem_type      push_item
);

   logic      hold_valid_ff;
   logic      hold_valid_in;
   qitem_type hold_item_ff;
   qitem_type hold_item_in;

   assign req_ready  = ~hold_valid_ff | push_ready;
   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

   always_comb begin
      hold_valid_in         = hold_valid_ff;
      hold_item_in          = hold_item_ff;
      if (req_ready) begin
         hold_valid_in         = req_valid;
         hold_item_in.cls      = classify(req_item.data_byte);
         hold_item_in.has_byte = ~req_item.no_byte;
         hold_item_in.last     = req_item.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

endmodule

`default_nettype wire

### hw/rtl/drfe_queue.sv
// Short register queue between the classifying front and the span tracker.
`default_nettype none

module drfe_queue import drfe_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire qitem_type push_item,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output qitem_type      pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_QW-1:0] FULL     = CNT_QW'(QUEUE_DEPTH);

   qitem_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff;
   logic [CNT_QW-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/drfe_back.sv
// Span tracker: counts fields, values and subvalues, notes the span and registers the result.
`default_nettype none

module drfe_back import drfe_pkg::*; #(
   parameter int MAX_RECORD_BYTES = DEF_MAX_RECORD_BYTES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   output logic                        q_pop,
   input  wire qitem_type              q_item,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_item
);

   localparam int POS_W = $clog2(MAX_RECORD_BYTES + 1);
   localparam int EXT_W = (POS_W > SPAN_LEN_W) ? POS_W : SPAN_LEN_W;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_RECORD_BYTES);
   localparam logic [EXT_W-1:0] START_SAT = EXT_W'(SPAN_START_MAX);
   localparam logic [EXT_W-1:0] LEN_SAT   = EXT_W'(SPAN_LEN_MAX);

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_OPEN,
      PH_DONE
   } phase_type;

   logic [CSR_DATA_W-1:0] field_num_ff;
   logic [CSR_DATA_W-1:0] value_num_ff;
   logic [CSR_DATA_W-1:0] sub_num_ff;
   sel_type               sel;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [CNT_W-1:0] fcnt_ff;
   logic [CNT_W-1:0] fcnt_in;
   logic [CNT_W-1:0] vcnt_ff;
   logic [CNT_W-1:0] vcnt_in;
   logic [CNT_W-1:0] scnt_ff;
   logic [CNT_W-1:0] scnt_in;
   logic [POS_W-1:0] start_ff;
   logic [POS_W-1:0] start_in;
   logic [POS_W-1:0] end_ff;
   logic [POS_W-1:0] end_in;
   phase_type        phase_ff;
   phase_type        phase_in;
   logic             ovf_ff;
   logic             ovf_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_item_ff;
   rsp_type          rsp_item_in;

   logic [EXT_W-1:0] st_ext;
   logic [EXT_W-1:0] len_ext;
   logic             finish;

   assign sel       = sel_decode(field_num_ff, value_num_ff, sub_num_ff);
   assign q_pop     = q_valid & (~q_item.last | ~rsp_valid_ff | rsp_ready);
   assign finish    = q_pop & q_item.last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      pos_in      = pos_ff;
      fcnt_in     = fcnt_ff;
      vcnt_in     = vcnt_ff;
      scnt_in     = scnt_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      phase_in    = phase_ff;
      ovf_in      = ovf_ff;
      st_ext      = '0;
      len_ext     = '0;
      rsp_item_in = rsp_item_ff;

      if (q_pop && q_item.has_byte) begin
         if (pos_ff >= POS_LIMIT) begin
            ovf_in = 1'b1;
         end else begin
            if (phase_ff == PH_WAIT && sel_match(sel, fcnt_ff, vcnt_ff, scnt_ff)) begin
               phase_in = PH_OPEN;
               start_in = pos_ff;
            end
            if (phase_in == PH_OPEN && is_term(sel, q_item.cls)) begin
               phase_in = PH_DONE;
               end_in   = pos_ff;
            end
            unique case (q_item.cls)
               CLS_FIELD: begin
                  fcnt_in = sat_inc(fcnt_ff);
                  vcnt_in = CNT_ONE;
                  scnt_in = CNT_ONE;
               end
               CLS_VALUE: begin
                  vcnt_in = sat_inc(vcnt_ff);
                  scnt_in = CNT_ONE;
               end
               CLS_SUB: begin
                  scnt_in = sat_inc(scnt_ff);
               end
               default: begin
               end
            endcase
            pos_in = pos_ff + POS_W'(1);
         end
      end

      if (finish) begin
         if (phase_in == PH_WAIT && sel_match(sel, fcnt_in, vcnt_in, scnt_in)) begin
            phase_in = PH_OPEN;
            start_in = pos_in;
         end
         if (phase_in == PH_OPEN) begin
            phase_in = PH_DONE;
            end_in   = pos_in;
         end
         if (phase_in == PH_DONE) begin
            st_ext  = EXT_W'(start_in);
            len_ext = EXT_W'(end_in) - EXT_W'(start_in);
         end
         rsp_item_in.span_start      = (st_ext > START_SAT) ? SPAN_START_W'(SPAN_START_MAX)
                                                            : st_ext[SPAN_START_W-1:0];
         rsp_item_in.span_length     = (len_ext > LEN_SAT) ? SPAN_LEN_W'(SPAN_LEN_MAX)
                                                           : len_ext[SPAN_LEN_W-1:0];
         rsp_item_in.record_overflow = ovf_in | (st_ext > START_SAT) | (len_ext > LEN_SAT);
         pos_in   = '0;
         fcnt_in  = CNT_ONE;
         vcnt_in  = CNT_ONE;
         scnt_in  = CNT_ONE;
         start_in = '0;
         end_in   = '0;
         phase_in = PH_WAIT;
         ovf_in   = 1'b0;
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_num_ff <= '0;
         value_num_ff <= '0;
         sub_num_ff   <= '0;
         pos_ff       <= '0;
         fcnt_ff      <= CNT_ONE;
         vcnt_ff      <= CNT_ONE;
         scnt_ff      <= CNT_ONE;
         start_ff     <= '0;
         end_ff       <= '0;
         phase_ff     <= PH_WAIT;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIELD_NUMBER:    field_num_ff <= csr_data;
               CSR_VALUE_NUMBER:    value_num_ff <= csr_data;
               CSR_SUBVALUE_NUMBER: sub_num_ff   <= csr_data;
               default: begin
               end
            endcase
         end
         pos_ff       <= pos_in;
         fcnt_ff      <= fcnt_in;
         vcnt_ff      <= vcnt_in;
         scnt_ff      <= scnt_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         phase_ff     <= phase_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("byte position beyond record limit");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (end_ff >= start_ff))
      else $error("span end before span start");

   a_record_clear: assert property (@(posedge clock) disable iff (reset)
      finish |=> (pos_ff == '0) && (phase_ff == PH_WAIT) && rsp_valid_ff)
      else $error("record state not cleared at record end");

   a_counts_nonzero: assert property (@(posedge clock) disable iff (reset)
      (fcnt_ff != '0) && (vcnt_ff != '0) && (scnt_ff != '0))
      else $error("delimiter count at zero");

endmodule

`default_nettype wire

### hw/rtl/delimited_record_field_extract_unit.sv
// Top level of the delimited record field extractor.
//
// Record bytes come in on the req_ channel, one item per byte; last_byte marks
// the item that ends the record, no_byte an item with no byte in it (such an
// item with last_byte set ends the record, adding no byte). The csr_ port selects the
// field, value and subvalue; write it only between records.
// One result item per record leaves on the rsp_ channel: span start, span
// length and an overflow flag.
// Throughput: one item per cycle, except that a record's last item waits while
// a result is held; the span tracker updates counters and compares once per byte.
// A record's result passes the input register, a queue slot and the result
// register after its last item is accepted.
// When rsp_ready is low the result holds in its register; bytes that do not
// end a record keep flowing, and the two-entry queue and the input register
// absorb the rest before req_ready drops.
// Reset clears the selection to the whole record and empties all stages; no
// clearing pass is needed.
`default_nettype none

module delimited_record_field_extract_unit import drfe_pkg::*; #(
   parameter int MAX_RECORD_BYTES = DEF_MAX_RECORD_BYTES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_item,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic      push_valid;
   logic      push_ready;
   qitem_type push_item;
   logic      pop_valid;
   logic      pop_ready;
   qitem_type pop_item;

   drfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   drfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   drfe_back #(
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (pop_valid),
      .q_pop     (pop_ready),
      .q_item    (pop_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

### tb/delimited_record_field_extract_unit_test.sv
// Self-checking testbench for the delimited record field extractor.
`timescale 1ns / 1ps

module delimited_record_field_extract_unit_test;
   import drfe_pkg::*;

   localparam int CLOCK_HALF = 5;
   localparam int RESET_CYCLES = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 360;
   localparam int PRINT_CAP = 100;
   localparam int RECORD_LIMIT = DEF_MAX_RECORD_BYTES;
   localparam logic [14:0] COUNT_TOP = 15'h7FFF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum logic [1:0] {
      SPAN_SEEKING,
      SPAN_OPEN,
      SPAN_CLOSED
   } span_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   req_type byte_items[$];
   req_type record_buf[$];
   rsp_type spans_due[$];
   logic req_accepted = 1'b0;
   int send_idle_pct = 18;
   int recv_idle_pct = 77;
   int pushed_count = 0;
   int accepted_count = 0;
   int useful_items = 0;
   int records_sent = 0;
   int selections = 0;
   int spans_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // predictor state: selection registers and the record being tracked
   logic [15:0] sel_field = '0;
   logic [15:0] sel_value = '0;
   logic [15:0] sel_sub = '0;
   logic [16:0] rec_pos = '0;
   logic [14:0] fld_cnt = 15'd1;
   logic [14:0] val_cnt = 15'd1;
   logic [14:0] sub_cnt = 15'd1;
   logic [16:0] span_from = '0;
   logic [16:0] span_to = '0;
   span_state_type span_state = SPAN_SEEKING;
   logic rec_ovf = 1'b0;

   delimited_record_field_extract_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic logic [14:0] bump(input logic [14:0] c);
      return (c == COUNT_TOP) ? c : c + 15'd1;
   endfunction

   function automatic bit sel_hit(input bit none_sel, input depth_type d,
                                  input int fe, input int ve, input int se);
      if (none_sel) return 1'b0;
      if (d != DEPTH_RECORD && int'(fld_cnt) != fe) return 1'b0;
      if ((d == DEPTH_VALUE || d == DEPTH_SUB) && int'(val_cnt) != ve) return 1'b0;
      if (d == DEPTH_SUB && int'(sub_cnt) != se) return 1'b0;
      return 1'b1;
   endfunction

   task automatic restart_record();
      rec_pos = '0;
      fld_cnt = 15'd1;
      val_cnt = 15'd1;
      sub_cnt = 15'd1;
      span_from = '0;
      span_to = '0;
      span_state = SPAN_SEEKING;
      rec_ovf = 1'b0;
   endtask

   task automatic span_track(input req_type it, output bit produced, output rsp_type res);
      bit none_sel;
      depth_type dsel;
      int fe;
      int ve;
      int se;
      bit closes;
      logic [16:0] st;
      logic [16:0] len;
      bit ovf;
      none_sel = sel_field[15] || sel_value[15] || sel_sub[15];
      fe = 0;
      ve = 0;
      se = 0;
      if (sel_field == '0 && sel_value == '0 && sel_sub == '0) begin
         dsel = DEPTH_RECORD;
      end else begin
         fe = (sel_field == '0) ? 1 : int'(sel_field[14:0]);
         if (sel_value == '0 && sel_sub == '0) begin
            dsel = DEPTH_FIELD;
         end else begin
            ve = (sel_value == '0) ? 1 : int'(sel_value[14:0]);
            se = int'(sel_sub[14:0]);
            dsel = (sel_sub == '0) ? DEPTH_VALUE : DEPTH_SUB;
         end
      end
      if (!it.no_byte) begin
         if (rec_pos >= RECORD_LIMIT) begin
            rec_ovf = 1'b1;
         end else begin
            if (span_state == SPAN_SEEKING && sel_hit(none_sel, dsel, fe, ve, se)) begin
               span_state = SPAN_OPEN;
               span_from = rec_pos;
            end
            closes = (it.data_byte == DELIM_FIELD && dsel != DEPTH_RECORD)
                  || (it.data_byte == DELIM_VALUE && (dsel == DEPTH_VALUE || dsel == DEPTH_SUB))
                  || (it.data_byte == DELIM_SUB && dsel == DEPTH_SUB);
            if (span_state == SPAN_OPEN && closes) begin
               span_state = SPAN_CLOSED;
               span_to = rec_pos;
            end
            if (it.data_byte == DELIM_FIELD) begin
               fld_cnt = bump(fld_cnt);
               val_cnt = 15'd1;
               sub_cnt = 15'd1;
            end else if (it.data_byte == DELIM_VALUE) begin
               val_cnt = bump(val_cnt);
               sub_cnt = 15'd1;
            end else if (it.data_byte == DELIM_SUB) begin
               sub_cnt = bump(sub_cnt);
            end
            rec_pos = rec_pos + 17'd1;
         end
      end
      produced = it.last_byte;
      res = '0;
      if (it.last_byte) begin
         if (span_state == SPAN_SEEKING && sel_hit(none_sel, dsel, fe, ve, se)) begin
            span_state = SPAN_OPEN;
            span_from = rec_pos;
         end
         if (span_state == SPAN_OPEN) begin
            span_state = SPAN_CLOSED;
            span_to = rec_pos;
         end
         st = '0;
         len = '0;
         ovf = rec_ovf;
         if (span_state == SPAN_CLOSED) begin
            st = span_from;
            len = (span_to >= span_from) ? span_to - span_from : '0;
         end
         if (st > 17'hFFFF) begin
            st = 17'hFFFF;
            ovf = 1'b1;
         end
         if (len > 17'h10000) begin
            len = 17'h10000;
            ovf = 1'b1;
         end
         res.span_start = st[15:0];
         res.span_length = len;
         res.record_overflow = ovf;
         restart_record();
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
   endtask

   task automatic check_span(input rsp_type got);
      rsp_type want;
      if (spans_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result start %0d length %0d overflow %0b",
                                   got.span_start, got.span_length, got.record_overflow));
         return;
      end
      want = spans_due.pop_front();
      spans_checked++;
      if (got.span_start !== want.span_start)
         report_mismatch($sformatf("span_start %0d, want %0d", got.span_start,
                                   want.span_start));
      if (got.span_length !== want.span_length)
         report_mismatch($sformatf("span_length %0d, want %0d", got.span_length,
                                   want.span_length));
      if (got.record_overflow !== want.record_overflow)
         report_mismatch($sformatf("record_overflow %0b, want %0b", got.record_overflow,
                                   want.record_overflow));
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_accepted)) begin
         if (byte_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_item <= byte_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor and predictor
   always @(posedge clock) begin
      rsp_type predicted;
      bit has_result;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIELD_NUMBER:    sel_field = csr_data;
               CSR_VALUE_NUMBER:    sel_value = csr_data;
               CSR_SUBVALUE_NUMBER: sel_sub = csr_data;
               default: ;
            endcase
         end
         req_accepted <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            accepted_count++;
            span_track(req_item, has_result, predicted);
            if (has_result) spans_due.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) check_span(rsp_item);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               spans_due.size());
      $display("CHECK FAILED");
      $finish;
   end

   task automatic push_item(input logic [7:0] b, input bit last, input bit none);
      req_type it;
      it.data_byte = b;
      it.last_byte = last;
      it.no_byte = none;
      byte_items.push_back(it);
      pushed_count++;
      if (!none || last) useful_items++;
      if (last) records_sent++;
   endtask

   task automatic push_seq(input logic [95:0] seq, input int n);
      for (int i = 0; i < n; i++) push_item(seq[8*(n-1-i) +: 8], i == n - 1, 1'b0);
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (!(byte_items.size() == 0 && accepted_count == pushed_count
               && spans_due.size() == 0));
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_selection(input logic [15:0] f, input logic [15:0] v,
                                input logic [15:0] s);
      wait_quiet();
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED_INDEX, 16'($urandom));
      write_csr(CSR_FIELD_NUMBER, f);
      write_csr(CSR_VALUE_NUMBER, v);
      write_csr(CSR_SUBVALUE_NUMBER, s);
      selections++;
   endtask

   function automatic logic [15:0] pick_number();
      logic [15:0] n;
      case ($urandom_range(0, 19))
         0, 1, 2: n = 16'h0000;
         3:       n = 16'hFFFF;
         4:       n = 16'h7FFF;
         5:       n = 16'h8000;
         6:       n = 16'($urandom);
         default: n = 16'($urandom_range(1, 4));
      endcase
      return n;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == DELIM_FIELD || b == DELIM_VALUE || b == DELIM_SUB);
      return b;
   endfunction

   task automatic add_byte(input logic [7:0] b);
      req_type it;
      if ($urandom_range(0, 19) == 0) begin
         it.data_byte = 8'($urandom_range(0, 255));
         it.last_byte = 1'b0;
         it.no_byte = 1'b1;
         record_buf.push_back(it);
      end
      it.data_byte = b;
      it.last_byte = 1'b0;
      it.no_byte = 1'b0;
      record_buf.push_back(it);
   endtask

   task automatic build_nested();
      int nf;
      int nv;
      int ns;
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
         nv = $urandom_range(1, 3);
         for (int v = 0; v < nv; v++) begin
            ns = $urandom_range(1, 3);
            for (int s = 0; s < ns; s++) begin
               repeat ($urandom_range(0, 3)) add_byte(plain_byte());
               if (s < ns - 1) add_byte(DELIM_SUB);
            end
            if (v < nv - 1) add_byte(DELIM_VALUE);
         end
         if (f < nf - 1) add_byte(DELIM_FIELD);
      end
   endtask

   task automatic build_noise();
      req_type it;
      repeat ($urandom_range(0, 12)) begin
         case ($urandom_range(0, 5))
            0: add_byte(DELIM_FIELD);
            1: add_byte(DELIM_VALUE);
            2: add_byte(DELIM_SUB);
            3: begin
               it.data_byte = 8'($urandom_range(0, 255));
               it.last_byte = 1'b0;
               it.no_byte = 1'b1;
               record_buf.push_back(it);
            end
            default: add_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic commit_record();
      req_type tail;
      if (record_buf.size() == 0 || $urandom_range(0, 4) == 0) begin
         tail.data_byte = 8'($urandom_range(0, 255));
         tail.last_byte = 1'b1;
         tail.no_byte = 1'b1;
         record_buf.push_back(tail);
      end else begin
         record_buf[$].last_byte = 1'b1;
      end
      foreach (record_buf[i])
         push_item(record_buf[i].data_byte, record_buf[i].last_byte, record_buf[i].no_byte);
      record_buf.delete();
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct);
      int first;
      wait_quiet();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first = useful_items;
      while (useful_items - first < PHASE_ITEMS) begin
         set_selection(pick_number(), pick_number(), pick_number());
         repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(0, 3) == 0) build_noise();
            else build_nested();
            commit_record();
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // whole record: empty record, then bytes around an item without a byte
      set_selection(16'd0, 16'd0, 16'd0);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hFF, 1'b0, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'h00, 1'b1, 1'b0);
      // middle field, followed by an empty trailing field
      set_selection(16'd2, 16'd0, 16'd0);
      push_seq(96'({8'h41, DELIM_FIELD, 8'h42, DELIM_FIELD}), 4);
      set_selection(16'd1, 16'd2, 16'd3);
      push_seq(96'({8'h41, DELIM_VALUE, 8'h42, DELIM_SUB, 8'h43, DELIM_SUB, 8'h44}), 7);
      set_selection(16'd0, 16'd2, 16'd0);
      push_seq(96'({8'h41, DELIM_VALUE, 8'h42}), 3);
      set_selection(16'd0, 16'd0, 16'd2);
      push_seq(96'({8'h41, DELIM_SUB, 8'h42}), 3);
      set_selection(16'hFFFF, 16'd0, 16'd0);
      push_seq(96'({8'h41}), 1);
      // field that never occurs
      set_selection(16'd5, 16'd0, 16'd0);
      push_seq(96'({8'h41}), 1);
      set_selection(16'h7FFF, 16'h7FFF, 16'h7FFF);
      write_csr(CSR_UNUSED_INDEX, 16'hFFFF);
      push_seq(96'({8'h41}), 1);

      random_phase(18, 77);
      random_phase(77, 18);
      random_phase(0, 0);

      wait_quiet();
      $display("Covered %0d records, %0d items, %0d selections, three idling mixes",
               records_sent, pushed_count, selections);
      $display("%0d spans checked, including empty, missing and negative selections",
               spans_checked);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### delimited_record_field_extract_unit.f
hw/rtl/drfe_pkg.sv
hw/rtl/drfe_front.sv
hw/rtl/drfe_queue.sv
hw/rtl/drfe_back.sv
hw/rtl/delimited_record_field_extract_unit.sv
tb/delimited_record_field_extract_unit_test.sv
